/* hdl/bgd_pkg.sv */
`timescale 1ns / 1ps

package bgd_pkg;

    // Width of timestamps; all time differences wrap at this width.
    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 2;

    // Stream payload widths (fields packed from bit 0, padded to bytes).
    localparam int S_TDATA_BITS = ((TIME_BITS + 1 + 7) / 8) * 8;
    localparam int S_TUSER_BITS = 1;
    localparam int M_TDATA_BITS = 8;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SHORT  = 2'd1,
        GEST_LONG   = 2'd2,
        GEST_DOUBLE = 2'd3
    } gesture_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_DEBOUNCE_TIME   = 2'd0,
        REG_LONG_PRESS_TIME = 2'd1,
        REG_CLICK_WINDOW    = 2'd2
    } reg_index_t;

    localparam logic OP_RAW_CHANGE = 1'b0;
    localparam logic OP_TICK       = 1'b1;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd25;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd600;
    localparam logic [CFG_BITS-1:0] CLICK_WIN_RESET  = 16'd600;

endpackage

/* hdl/button_gesture_decoder.sv */
`timescale 1ns / 1ps

// Button gesture decoder.
// The slave stream carries one transaction per raw button level change or
// per time tick: s_tuser selects which, s_tdata holds the raw level and the
// millisecond timestamp. Every accepted transaction yields exactly one master
// transaction with the decoded gesture (none, short, long, double) and a
// press feedback flag that pulses when a debounced press is confirmed.
// Timing: a transaction is captured in an input register, decoded by one
// layer of parallel 32-bit subtract/compare logic against the debounce,
// long-press and click-window thresholds, and the result is registered in the
// output register once that register is free or being taken; throughput is
// one transaction per cycle while m_tready stays high, limited only by the
// single decode stage that updates the gesture state.
// When the master side stalls, the output register holds its transaction and
// the input register absorbs one more; s_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both registers, clears all gesture
// state and restores the thresholds to 25, 600 and 600 ms.
// The cfg port writes a threshold whenever cfg_wr_en is high; write it only
// while no transaction is in flight.
module button_gesture_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [bgd_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [bgd_pkg::CFG_BITS-1:0]        cfg_wdata,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] raw_level, [32:1] time_ms, [39:33] zero
    input  logic [bgd_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // [0] op (0 raw change, 1 tick)
    input  logic [bgd_pkg::S_TUSER_BITS-1:0]    s_tuser,
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] gesture, [2] press_feedback, [7:3] zero
    output logic [bgd_pkg::M_TDATA_BITS-1:0]    m_tdata
);

    localparam int TB = bgd_pkg::TIME_BITS;

    // Thresholds
    logic [bgd_pkg::CFG_BITS-1:0] debounce_reg;
    logic [bgd_pkg::CFG_BITS-1:0] long_press_reg;
    logic [bgd_pkg::CFG_BITS-1:0] click_win_reg;

    // Input register
    logic          in_valid_reg;
    logic          in_op_reg;
    logic          in_lvl_reg;
    logic [TB-1:0] in_time_reg;

    // Output register
    logic              out_valid_reg;
    bgd_pkg::gesture_t out_gest_reg;
    logic              out_fb_reg;

    // Gesture state
    logic          last_raw_reg,      last_raw_next;
    logic          pend_valid_reg,    pend_valid_next;
    logic          pend_level_reg,    pend_level_next;
    logic [TB-1:0] pend_time_reg,     pend_time_next;
    logic          stable_reg,        stable_next;
    logic [TB-1:0] press_time_reg,    press_time_next;
    logic          long_done_reg,     long_done_next;
    logic          double_wait_reg,   double_wait_next;
    logic          tap_pending_reg,   tap_pending_next;
    logic [TB-1:0] release_time_reg,  release_time_next;

    bgd_pkg::gesture_t gest_next;
    logic              fb_next;

    logic advance;
    logic process;

    // Parallel elapsed-time terms
    logic [TB-1:0] d_pend;      // now - pending change
    logic [TB-1:0] d_press;     // now - press
    logic [TB-1:0] d_release;   // now - release
    logic [TB-1:0] pd_press;    // pending change - press
    logic [TB-1:0] pd_release;  // pending change - release
    logic          confirm_ok;
    logic          check;
    logic          edge_press;
    logic          edge_release;
    logic [TB-1:0] long_elapsed;
    logic [TB-1:0] short_elapsed;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_fb_reg, out_gest_reg};

    assign d_pend     = in_time_reg - pend_time_reg;
    assign d_press    = in_time_reg - press_time_reg;
    assign d_release  = in_time_reg - release_time_reg;
    assign pd_press   = pend_time_reg - press_time_reg;
    assign pd_release = pend_time_reg - release_time_reg;

    assign confirm_ok = pend_valid_reg && (d_pend >= TB'(debounce_reg));

    // A raw change that repeats the last raw level is a no-op.
    assign check = (in_op_reg == bgd_pkg::OP_TICK) || (in_lvl_reg != last_raw_reg);

    assign edge_press   = check && confirm_ok && (pend_level_reg != stable_reg)
                          && pend_level_reg;
    assign edge_release = check && confirm_ok && (pend_level_reg != stable_reg)
                          && !pend_level_reg;

    // After a confirmed edge the press/release stamp is the pending timestamp.
    assign long_elapsed  = edge_press   ? d_pend : d_press;
    assign short_elapsed = edge_release ? d_pend : d_release;

    always_comb begin
        last_raw_next     = last_raw_reg;
        pend_valid_next   = pend_valid_reg;
        pend_level_next   = pend_level_reg;
        pend_time_next    = pend_time_reg;
        stable_next       = stable_reg;
        press_time_next   = press_time_reg;
        long_done_next    = long_done_reg;
        double_wait_next  = double_wait_reg;
        tap_pending_next  = tap_pending_reg;
        release_time_next = release_time_reg;
        gest_next         = bgd_pkg::GEST_NONE;
        fb_next           = 1'b0;

        if (check && confirm_ok) begin
            pend_valid_next = 1'b0;
        end

        // Apply the confirmed edge.
        if (edge_press) begin
            stable_next     = 1'b1;
            press_time_next = pend_time_reg;
            long_done_next  = 1'b0;
            fb_next         = 1'b1;
            if (tap_pending_reg && (pd_release <= TB'(click_win_reg))) begin
                double_wait_next = 1'b1;
                tap_pending_next = 1'b0;
                long_done_next   = 1'b1;
                gest_next        = bgd_pkg::GEST_DOUBLE;
            end
        end else if (edge_release) begin
            stable_next = 1'b0;
            if (long_done_reg) begin
                long_done_next   = 1'b0;
                tap_pending_next = 1'b0;
                double_wait_next = 1'b0;
            end else if (pd_press >= TB'(long_press_reg)) begin
                tap_pending_next = 1'b0;
            end else begin
                tap_pending_next  = 1'b1;
                release_time_next = pend_time_reg;
            end
        end

        if (in_op_reg == bgd_pkg::OP_RAW_CHANGE) begin
            if (check) begin
                // Latch the new raw change as pending.
                last_raw_next   = in_lvl_reg;
                pend_valid_next = 1'b1;
                pend_level_next = in_lvl_reg;
                pend_time_next  = in_time_reg;
            end
        end else begin
            // Long press fires while still held.
            if (stable_next && !long_done_next
                && (long_elapsed >= TB'(long_press_reg))) begin
                long_done_next   = 1'b1;
                tap_pending_next = 1'b0;
                double_wait_next = 1'b0;
                gest_next        = bgd_pkg::GEST_LONG;
            end
            // Single tap once the click window has run out.
            if (tap_pending_next && !double_wait_next && !stable_next
                && !pend_valid_next && (short_elapsed > TB'(click_win_reg))) begin
                tap_pending_next = 1'b0;
                gest_next        = bgd_pkg::GEST_SHORT;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= bgd_pkg::DEBOUNCE_RESET;
            long_press_reg <= bgd_pkg::LONG_PRESS_RESET;
            click_win_reg  <= bgd_pkg::CLICK_WIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bgd_pkg::REG_DEBOUNCE_TIME:   debounce_reg   <= cfg_wdata;
                bgd_pkg::REG_LONG_PRESS_TIME: long_press_reg <= cfg_wdata;
                bgd_pkg::REG_CLICK_WINDOW:    click_win_reg  <= cfg_wdata;
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // Input register: load on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser[0];
            in_lvl_reg  <= s_tdata[0];
            in_time_reg <= s_tdata[TB:1];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_gest_reg <= gest_next;
            out_fb_reg   <= fb_next;
        end
    end

    // Gesture state: advance once per decoded transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg     <= 1'b0;
            pend_valid_reg   <= 1'b0;
            pend_level_reg   <= 1'b0;
            pend_time_reg    <= '0;
            stable_reg       <= 1'b0;
            press_time_reg   <= '0;
            long_done_reg    <= 1'b0;
            double_wait_reg  <= 1'b0;
            tap_pending_reg  <= 1'b0;
            release_time_reg <= '0;
        end else if (process) begin
            last_raw_reg     <= last_raw_next;
            pend_valid_reg   <= pend_valid_next;
            pend_level_reg   <= pend_level_next;
            pend_time_reg    <= pend_time_next;
            stable_reg       <= stable_next;
            press_time_reg   <= press_time_next;
            long_done_reg    <= long_done_next;
            double_wait_reg  <= double_wait_next;
            tap_pending_reg  <= tap_pending_next;
            release_time_reg <= release_time_next;
        end
    end

    // A double press is always a confirmed press.
    a_double_has_fb: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_gest_reg == bgd_pkg::GEST_DOUBLE) |-> out_fb_reg)
        else $error("double gesture without press feedback");

    // A short tap is only reported with the button released.
    a_short_no_fb: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_gest_reg == bgd_pkg::GEST_SHORT) |-> !out_fb_reg)
        else $error("short gesture together with press feedback");

    // The double-wait flag lives only inside a held press marked done.
    a_double_wait_held: assert property (@(posedge aclk) disable iff (!aresetn)
        double_wait_reg |-> (stable_reg && long_done_reg))
        else $error("double wait outside a held double press");

    // Nothing decoded while the input register is empty.
    a_state_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(in_valid_reg) |-> $stable(stable_reg) && $stable(pend_valid_reg))
        else $error("gesture state moved without a transaction");

endmodule

/* tb/button_gesture_decoder_tb.sv */
`timescale 1ns / 1ps

module button_gesture_decoder_tb;

    localparam int TW = bgd_pkg::TIME_BITS;
    localparam int CW = bgd_pkg::CFG_BITS;

    // Index 3 is not mapped to any threshold; a write there must change nothing.
    localparam logic [bgd_pkg::IDX_BITS-1:0] REG_UNMAPPED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;

    // One slave transaction: a raw level change or a time tick.
    typedef struct packed {
        logic          op;
        logic          level;
        logic [TW-1:0] stamp;
    } button_evt_t;

    // One master transaction as the decoder should produce it.
    typedef struct packed {
        bgd_pkg::gesture_t gesture;
        logic              feedback;
    } gesture_out_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [bgd_pkg::IDX_BITS-1:0]     cfg_index;
    logic [CW-1:0]                    cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    // [0] raw_level, [32:1] time_ms, [39:33] zero
    logic [bgd_pkg::S_TDATA_BITS-1:0] s_tdata;
    // [0] op (0 raw change, 1 tick)
    logic [bgd_pkg::S_TUSER_BITS-1:0] s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    // [1:0] gesture, [2] press_feedback, [7:3] zero
    logic [bgd_pkg::M_TDATA_BITS-1:0] m_tdata;

    button_gesture_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Gesture predictor: thresholds and debounce/gesture state of its own.
    // ------------------------------------------------------------------
    logic [CW-1:0] cfg_debounce;
    logic [CW-1:0] cfg_long_press;
    logic [CW-1:0] cfg_window;

    logic          raw_seen;       // last raw level seen on a change
    logic          pend_valid;     // raw change waiting to be debounced
    logic          pend_level;
    logic [TW-1:0] pend_stamp;
    logic          debounced;      // confirmed button level
    logic [TW-1:0] press_stamp;
    logic          long_fired;     // long or double already reported
    logic          dbl_hold;       // second press of a double still held
    logic          tap_armed;      // short release waiting for its window
    logic [TW-1:0] release_stamp;

    function automatic void clear_gesture_state();
        cfg_debounce   = bgd_pkg::DEBOUNCE_RESET;
        cfg_long_press = bgd_pkg::LONG_PRESS_RESET;
        cfg_window     = bgd_pkg::CLICK_WIN_RESET;
        raw_seen       = 1'b0;
        pend_valid     = 1'b0;
        pend_level     = 1'b0;
        pend_stamp     = '0;
        debounced      = 1'b0;
        press_stamp    = '0;
        long_fired     = 1'b0;
        dbl_hold       = 1'b0;
        tap_armed      = 1'b0;
        release_stamp  = '0;
    endfunction

    // Elapsed milliseconds, wrapping at the timestamp width.
    function automatic logic [TW-1:0] since(input logic [TW-1:0] later,
                                            input logic [TW-1:0] earlier);
        return later - earlier;
    endfunction

    // Apply a debounced edge that happened at the raw time 'stamp'.
    function automatic gesture_out_t settle_edge(input logic pressed,
                                                 input logic [TW-1:0] stamp);
        gesture_out_t r;
        r.gesture  = bgd_pkg::GEST_NONE;
        r.feedback = 1'b0;
        if (pressed == debounced)
            return r;
        debounced = pressed;
        if (pressed) begin
            press_stamp = stamp;
            long_fired  = 1'b0;
            r.feedback  = 1'b1;
            // second press inside the click window after a short tap
            if (tap_armed && since(stamp, release_stamp) <= TW'(cfg_window)) begin
                dbl_hold   = 1'b1;
                tap_armed  = 1'b0;
                long_fired = 1'b1;
                r.gesture  = bgd_pkg::GEST_DOUBLE;
            end
        end else if (long_fired) begin
            // release after a long press or a double: no tap
            long_fired = 1'b0;
            tap_armed  = 1'b0;
            dbl_hold   = 1'b0;
        end else if (since(stamp, press_stamp) >= TW'(cfg_long_press)) begin
            // held long enough but no tick fired the long press: no tap either
            tap_armed = 1'b0;
        end else begin
            tap_armed     = 1'b1;
            release_stamp = stamp;
        end
        return r;
    endfunction

    function automatic gesture_out_t decode_event(input button_evt_t ev);
        gesture_out_t r;
        r.gesture  = bgd_pkg::GEST_NONE;
        r.feedback = 1'b0;
        if (ev.op == bgd_pkg::OP_RAW_CHANGE) begin
            // a repeated raw level is dropped without effect
            if (ev.level != raw_seen) begin
                raw_seen = ev.level;
                if (pend_valid && since(ev.stamp, pend_stamp) >= TW'(cfg_debounce))
                    r = settle_edge(pend_level, pend_stamp);
                // a pending change that did not hold is simply replaced
                pend_valid = 1'b1;
                pend_level = ev.level;
                pend_stamp = ev.stamp;
            end
        end else begin
            if (pend_valid && since(ev.stamp, pend_stamp) >= TW'(cfg_debounce)) begin
                r = settle_edge(pend_level, pend_stamp);
                pend_valid = 1'b0;
            end
            if (debounced && !long_fired &&
                since(ev.stamp, press_stamp) >= TW'(cfg_long_press)) begin
                long_fired = 1'b1;
                tap_armed  = 1'b0;
                dbl_hold   = 1'b0;
                r.gesture  = bgd_pkg::GEST_LONG;
            end
            if (tap_armed && !dbl_hold && !debounced && !pend_valid &&
                since(ev.stamp, release_stamp) > TW'(cfg_window)) begin
                tap_armed = 1'b0;
                r.gesture = bgd_pkg::GEST_SHORT;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Queues and counters shared by stimulus, driver and monitor.
    // ------------------------------------------------------------------
    button_evt_t  event_q[$];       // transactions not yet offered
    gesture_out_t gesture_q[$];     // predicted results, oldest first
    int           events_queued   = 0;
    int           events_accepted = 0;
    int           results_checked = 0;
    int           errors          = 0;
    int           cycle_count     = 0;

    // Mostly short gaps, a few long ones; a burst mode gives stretches without gaps.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued events on the slave stream.
    // ------------------------------------------------------------------
    button_evt_t cur_evt;
    int          tx_gap   = 0;
    bit          tx_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // predict at acceptance, so the model sees events in block order
            if (s_tvalid && s_tready) begin
                gesture_q.push_back(decode_event(cur_evt));
                events_accepted++;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = ~tx_burst;
                tx_gap = pick_gap(tx_burst);
            end
            // hold the offered transaction until it is taken
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    cur_evt = event_q.pop_front();
                    s_tdata  <= {{(bgd_pkg::S_TDATA_BITS - TW - 1){1'b0}},
                                 cur_evt.stamp, cur_evt.level};
                    s_tuser  <= cur_evt.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver stall: hold m_tready low twice, after the 500th and 1300th result.
    // ------------------------------------------------------------------
    int rx_seen = 0;
    int rx_hold = 0;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_seen <= rx_seen + 1;
            if (rx_seen == 499 || rx_seen == 1299)
                rx_hold <= 400;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each master transaction against the oldest prediction.
    // ------------------------------------------------------------------
    gesture_out_t want;
    int           rx_gap   = 0;
    bit           rx_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (gesture_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got tdata %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = gesture_q.pop_front();
                    if (m_tdata[1:0] !== want.gesture) begin
                        $display("%0t: gesture mismatch, expected %0d, got %0d",
                                 $time, want.gesture, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[2] !== want.feedback) begin
                        $display("%0t: press feedback mismatch, expected %0b, got %0b",
                                 $time, want.feedback, m_tdata[2]);
                        errors++;
                    end
                end
                results_checked++;
                if ($urandom_range(0, 39) == 0)
                    rx_burst = ~rx_burst;
                rx_gap = pick_gap(rx_burst);
            end
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("button_gesture_decoder test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    logic [TW-1:0] now_ms;     // timeline of the generated button

    function automatic int unsigned rnd(input int unsigned lo, input int unsigned hi);
        return $urandom_range(hi, lo);
    endfunction

    task automatic push_item(input logic op, input logic level,
                             input logic [TW-1:0] stamp);
        button_evt_t ev;
        ev.op    = op;
        ev.level = level;
        ev.stamp = stamp;
        event_q.push_back(ev);
        events_queued++;
    endtask

    // ticks carry a random, ignored raw level bit
    task automatic push_tick();
        push_item(bgd_pkg::OP_TICK, 1'($urandom_range(0, 1)), now_ms);
    endtask

    task automatic advance(input int unsigned dt);
        now_ms = now_ms + dt;
    endtask

    // Let 'dur' ms pass with up to three ticks along the way.
    task automatic spend(input int unsigned dur);
        int unsigned k;
        int unsigned part;
        k    = $urandom_range(0, 3);
        part = dur / (k + 1);
        repeat (k) begin
            advance(part);
            push_tick();
        end
        advance(dur - part * k);
    endtask

    // Raw edge to 'level', sometimes preceded by contact bounce shorter than debounce.
    task automatic raw_edge(input logic level);
        int unsigned n;
        n = (cfg_debounce > 2 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            push_item(bgd_pkg::OP_RAW_CHANGE, level, now_ms);
            advance(rnd(1, 32'(cfg_debounce) - 1));
            push_item(bgd_pkg::OP_RAW_CHANGE, !level, now_ms);
            advance(rnd(1, 32'(cfg_debounce) - 1));
        end
        push_item(bgd_pkg::OP_RAW_CHANGE, level, now_ms);
    endtask

    task automatic noise_item();
        case ($urandom_range(0, 3))
            0: push_item(bgd_pkg::OP_RAW_CHANGE, 1'($urandom_range(0, 1)),
                         now_ms + rnd(0, 40));
            1: push_item(bgd_pkg::OP_TICK, 1'($urandom_range(0, 1)), $urandom());
            2: begin
                now_ms = $urandom();
                push_tick();
            end
            default: push_item(bgd_pkg::OP_RAW_CHANGE, 1'($urandom_range(0, 1)), $urandom());
        endcase
    endtask

    // One well-formed gesture with random timing, or a little noise.
    task automatic add_gesture();
        int unsigned d;
        int unsigned lp;
        int unsigned w;
        int          pick;
        d    = 32'(cfg_debounce);
        lp   = 32'(cfg_long_press);
        w    = 32'(cfg_window);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // tap, then let the window run out
            raw_edge(1'b1);
            spend(rnd(d, d + lp));
            raw_edge(1'b0);
            spend(rnd(d, d + w + w / 2 + 2));
            push_tick();
        end else if (pick < 50) begin
            // two taps, second press usually inside the window
            raw_edge(1'b1);
            spend(rnd(d, d + lp / 2));
            raw_edge(1'b0);
            spend(rnd(d, d + w));
            raw_edge(1'b1);
            spend(rnd(d, d + lp));
            raw_edge(1'b0);
            spend(rnd(d, d + w + 2));
            push_tick();
        end else if (pick < 70) begin
            // hold around the long press threshold
            raw_edge(1'b1);
            spend(rnd(lp, lp + d + 50));
            push_tick();
            raw_edge(1'b0);
            spend(rnd(d, d + w + 2));
            push_tick();
        end else if (pick < 85) begin
            // glitch about as short as the debounce time
            push_item(bgd_pkg::OP_RAW_CHANGE, 1'b1, now_ms);
            advance(rnd(0, d));
            push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, now_ms);
            spend(rnd(0, 2 * d + 2));
            push_tick();
        end else begin
            repeat ($urandom_range(1, 4))
                noise_item();
        end
    endtask

    task automatic run_gestures(input int count);
        int target;
        target = events_queued + count;
        while (events_queued < target)
            add_gesture();
    endtask

    // Pause the sender until every offered event has come back.
    task automatic drain();
        while (!(events_accepted == events_queued && gesture_q.size() == 0))
            @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bgd_pkg::IDX_BITS-1:0] idx,
                             input logic [CW-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bgd_pkg::REG_DEBOUNCE_TIME:   cfg_debounce   = val;
            bgd_pkg::REG_LONG_PRESS_TIME: cfg_long_press = val;
            bgd_pkg::REG_CLICK_WINDOW:    cfg_window     = val;
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input logic [CW-1:0] deb,
                                  input logic [CW-1:0] lng,
                                  input logic [CW-1:0] win);
        drain();
        write_reg(bgd_pkg::REG_DEBOUNCE_TIME, deb);
        write_reg(bgd_pkg::REG_LONG_PRESS_TIME, lng);
        write_reg(bgd_pkg::REG_CLICK_WINDOW, win);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        now_ms    = '0;
        clear_gesture_state();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset thresholds (25 / 600 / 600 ms).
        push_item(bgd_pkg::OP_TICK,       1'b1, 32'd0);
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, 32'd10);     // repeats released level
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b1, 32'd100);
        push_item(bgd_pkg::OP_TICK,       1'b0, 32'd110);    // not held long enough yet
        push_item(bgd_pkg::OP_TICK,       1'b1, 32'd125);    // press confirmed at debounce
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, 32'd300);
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b1, 32'd310);    // release bounce superseded
        push_item(bgd_pkg::OP_TICK,       1'b0, 32'd400);    // confirmed equals stable
        push_item(bgd_pkg::OP_TICK,       1'b1, 32'd700);    // long press fires while held
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, 32'd800);
        push_item(bgd_pkg::OP_TICK,       1'b0, 32'd900);    // release after long: no tap
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b1, 32'd1000);
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, 32'd1100);   // press confirmed on a change
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b1, 32'd1300);   // short release, tap armed
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, 32'd1400);   // double on a raw change
        push_item(bgd_pkg::OP_TICK,       1'b1, 32'd1500);   // release after double: no tap
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b1, 32'd4000);
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, 32'd4100);
        push_item(bgd_pkg::OP_TICK,       1'b0, 32'd4200);   // window still open
        push_item(bgd_pkg::OP_TICK,       1'b1, 32'd4701);   // window expired: short
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b1, 32'd5000);
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, 32'd5700);
        push_item(bgd_pkg::OP_TICK,       1'b0, 32'd5800);   // long hold never fired: no tap
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b1, 32'hFFFF_FFFF);
        push_item(bgd_pkg::OP_TICK,       1'b1, 32'h0000_0018); // debounce across the wrap
        push_item(bgd_pkg::OP_RAW_CHANGE, 1'b0, 32'h0000_0020);
        now_ms = 32'h0000_0100;

        // Random part: several threshold settings, extremes among them.
        set_thresholds(16'd25, 16'd600, 16'd600);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        run_gestures(280);
        set_thresholds(16'd0, 16'd0, 16'd0);
        run_gestures(280);
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_gestures(280);
        set_thresholds(CW'(rnd(0, 60)), CW'(rnd(0, 1500)), CW'(rnd(0, 1500)));
        run_gestures(280);
        set_thresholds(16'd0, 16'hFFFF, 16'hFFFF);
        run_gestures(280);
        set_thresholds(CW'(rnd(1, 30)), CW'(rnd(50, 900)), CW'(rnd(0, 300)));
        run_gestures(280);

        drain();
        repeat (6) @(posedge aclk);
        if (errors == 0)
            $display("button_gesture_decoder test passed");
        else
            $display("button_gesture_decoder test failed");
        $finish;
    end

endmodule
